// ===== rtl/upd_pkg.sv =====
`default_nettype none

package upd_pkg;

  localparam logic [7:0] PCT_CHAR  = 8'h25;
  localparam logic [7:0] NOT_HEX   = 8'hFF;
  localparam int         NIBBLE_SH = 4;

  localparam int RUN_MAX     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // one run of decoded bytes caused by a single input item
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    last;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/url_percent_decoder.sv =====
// URL percent decoder, one encoded byte per input item.
// Input channel: in_valid / in_stall with in_byte and in_last (last byte of
// the string). Output channel: out_valid / out_stall with out_byte, run_end
// (last result of one input item) and string_end (last result of a string).
// The front end tracks a held '%' and hex digit and turns each input item
// into a run of 0 to 3 output bytes, pushed into a 4-entry queue. The back
// end drains the queue one byte per cycle, while the output is not stalled,
// into a registered output stage. An accepted item's run is written into the
// queue, and its first byte then moves into the output stage. Throughput: one
// input item per cycle while runs are one byte long and the output is not
// stalled; the back end emits longer runs from flushes and broken escapes
// byte by byte, and the queue absorbs them.
// in_stall rises only when the queue is full. When out_stall is high the
// output holds its item and the queue fills behind it.
// Reset (rst, synchronous, active high) drops anything held or queued and
// clears the escape state.
`default_nettype none

module url_percent_decoder
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_end,
  output logic            string_end
);

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t wr_job;
  job_t head;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .push     (push),
    .job      (wr_job)
  );

  upd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (head)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule

`default_nettype wire

// ===== rtl/upd_front.sv =====
`default_nettype none

module upd_front
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       q_full,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            push,
  output job_t            job
);

  logic [1:0] held_count;
  logic [7:0] held_digit;
  logic [1:0] held_count_next;
  logic [7:0] held_digit_next;

  logic [RUN_MAX-1:0][7:0] nb;
  logic [1:0]              n;
  logic                    plain;
  logic [7:0]              lo;
  logic [7:0]              hi;
  logic                    accept;

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end else begin
      v = NOT_HEX;
    end
    return v;
  endfunction

  always_comb begin
    nb              = '0;
    n               = 2'd0;
    plain           = 1'b0;
    held_count_next = 2'd0;
    held_digit_next = held_digit;
    lo              = hex_val(in_byte);
    hi              = hex_val(held_digit);
    unique case (held_count)
      2'd1: begin
        if (lo != NOT_HEX) begin
          held_count_next = 2'd2;
          held_digit_next = in_byte;
        end else begin
          nb[n] = PCT_CHAR;
          n     = n + 2'd1;
          plain = 1'b1;
        end
      end
      2'd2: begin
        if (lo != NOT_HEX) begin
          nb[n] = {hi[3:0], lo[3:0]};
          n     = n + 2'd1;
        end else begin
          nb[n] = PCT_CHAR;
          n     = n + 2'd1;
          nb[n] = held_digit;
          n     = n + 2'd1;
          plain = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase
    if (plain) begin
      if (in_byte == PCT_CHAR) begin
        held_count_next = 2'd1;
      end else begin
        nb[n] = in_byte;
        n     = n + 2'd1;
      end
    end
    if (in_last) begin
      if (held_count_next != 2'd0) begin
        nb[n] = PCT_CHAR;
        n     = n + 2'd1;
      end
      if (held_count_next == 2'd2) begin
        nb[n] = held_digit_next;
        n     = n + 2'd1;
      end
      held_count_next = 2'd0;
      held_digit_next = 8'd0;
    end
  end

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign push      = accept && (n != 2'd0);
  assign job.bytes = nb;
  assign job.cnt   = n;
  assign job.last  = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      held_digit <= 8'd0;
    end else if (accept) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/upd_queue.sv =====
`default_nettype none

module upd_queue
  import upd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output job_t      head
);

  job_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;

  assign full  = (fill == QFILL_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/upd_back.sv =====
`default_nettype none

module upd_back
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire job_t       head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_end,
  output logic            string_end
);

  logic [1:0] idx;
  logic       emit;
  logic       final_byte;

  assign emit       = !q_empty && (!out_valid || !out_stall);
  assign final_byte = (idx == head.cnt - 2'd1);
  assign pop        = emit && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        idx <= 2'd0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= head.bytes[idx];
      run_end    <= final_byte;
      string_end <= final_byte && head.last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/url_percent_decoder_tb.sv =====
`timescale 1ns / 100ps

module url_percent_decoder_tb;
  import upd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 40;
  localparam int PHASE_ITEMS    = 48;
  localparam int DIR_ROWS       = 25;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_PCT, HOLD_PCT_DIGIT} hold_e;

  typedef struct packed {
    logic [7:0] b;
    logic       run_end;
    logic       string_end;
  } dec_out_t;

  typedef struct packed {
    logic [7:0]      b;
    logic            l;
    logic            typed;
    logic [1:0]      n;
    logic [2:0][7:0] e;
  } dir_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  hold_e      held_cnt = HOLD_NONE;
  logic [7:0] held_dig = 8'h00;
  dec_out_t   decoded_q[$];

  int errors      = 0;
  int n_items     = 0;
  int n_strings   = 0;
  int n_results   = 0;
  int n_triples   = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit long_hold_req = 1'b0;
  int hold_left   = 0;
  int quiet       = 0;

  url_percent_decoder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h37;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h57;
    return NOT_HEX;
  endfunction

  // advances the escape state by one byte, returns how many bytes it releases and puts them in run
  function automatic int predict_run(input logic [7:0] b, input logic l,
                                     output logic [2:0][7:0] run);
    int n;
    logic plain;
    logic [7:0] lo;
    logic [7:0] hi;
    n = 0;
    plain = 1'b0;
    run = '0;
    case (held_cnt)
      HOLD_PCT: begin
        if (hex_nibble(b) != NOT_HEX) begin
          held_cnt = HOLD_PCT_DIGIT;
          held_dig = b;
        end else begin
          run[n] = PCT_CHAR;
          n++;
          held_cnt = HOLD_NONE;
          plain = 1'b1;
        end
      end
      HOLD_PCT_DIGIT: begin
        lo = hex_nibble(b);
        if (lo != NOT_HEX) begin
          hi = hex_nibble(held_dig);
          run[n] = {hi[3:0], lo[3:0]};
          n++;
        end else begin
          run[n] = PCT_CHAR;
          n++;
          run[n] = held_dig;
          n++;
          plain = 1'b1;
        end
        held_cnt = HOLD_NONE;
      end
      default: begin
        held_cnt = HOLD_NONE;
        plain = 1'b1;
      end
    endcase
    if (plain) begin
      if (b == PCT_CHAR) begin
        held_cnt = HOLD_PCT;
      end else begin
        run[n] = b;
        n++;
      end
    end
    if (l) begin
      if (held_cnt != HOLD_NONE) begin
        run[n] = PCT_CHAR;
        n++;
      end
      if (held_cnt == HOLD_PCT_DIGIT) begin
        run[n] = held_dig;
        n++;
      end
      held_cnt = HOLD_NONE;
      held_dig = 8'h00;
    end
    return n;
  endfunction

  function automatic void queue_run(input logic [2:0][7:0] run, input int n, input logic l);
    dec_out_t d;
    for (int i = 0; i < n; i++) begin
      d.b = run[i];
      d.run_end = (i == n - 1);
      d.string_end = l && (i == n - 1);
      decoded_q.push_back(d);
    end
  endfunction

  function automatic dir_row_t mk_row(input logic [7:0] b, input logic l, input logic typed,
                                      input logic [1:0] n, input logic [7:0] e0,
                                      input logic [7:0] e1, input logic [7:0] e2);
    dir_row_t r;
    r.b = b;
    r.l = l;
    r.typed = typed;
    r.n = n;
    r.e = {e2, e1, e0};
    return r;
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(15));
    if (v < 8'd10) return v + 8'h30;
    return v + ($urandom_range(1) ? 8'h37 : 8'h57);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    case ($urandom_range(7))
      0: c = 8'h2F;
      1: c = 8'h3A;
      2: c = 8'h40;
      3: c = 8'h47;
      4: c = 8'h60;
      5: c = 8'h67;
      6: c = PCT_CHAR;
      default: begin
        do c = 8'($urandom_range(255)); while (hex_nibble(c) != NOT_HEX);
      end
    endcase
    return c;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic l, input bit typed,
                           input int tn, input logic [2:0][7:0] trun);
    logic [2:0][7:0] run;
    int n;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
    n = predict_run(b, l, run);
    if (typed) queue_run(trun, tn, l);
    else queue_run(run, n, l);
    n_items++;
    if (l) n_strings++;
    if (n == 3) n_triples++;
  endtask

  // mostly escapes and plain text, some broken escapes and raw bytes
  task automatic send_string();
    logic [7:0] s[$];
    int len;
    int r;
    len = $urandom_range(1, 8);
    while (s.size() < len) begin
      r = $urandom_range(99);
      if (r < 30) begin
        s.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (r < 60) begin
        s.push_back(PCT_CHAR);
        s.push_back(hex_char());
        s.push_back(hex_char());
      end else if (r < 75) begin
        s.push_back(PCT_CHAR);
        if ($urandom_range(1)) s.push_back(hex_char());
        s.push_back(non_hex());
      end else if (r < 88) begin
        s.push_back(8'($urandom_range(255)));
      end else begin
        s.push_back(PCT_CHAR);
      end
    end
    while (s.size() > len) void'(s.pop_back());
    foreach (s[i]) send_item(s[i], i == s.size() - 1, 1'b0, 0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  initial begin : rx_side
    dec_out_t w;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item out_byte=%02h run_end=%0b string_end=%0b",
                   $time, out_byte, run_end, string_end);
        end else begin
          w = decoded_q.pop_front();
          n_results++;
          if ({out_byte, run_end, string_end} !== w) begin
            errors++;
            $display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b (byte/run_end/string_end)",
                     $time, w.b, w.run_end, w.string_end, out_byte, run_end, string_end);
          end
        end
      end
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("url_percent_decoder: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [DIR_ROWS];
    int start;
    // byte, last, typed, count, expected bytes in order
    dir_rows[0]  = mk_row(8'h41,    1'b0, 1'b1, 2'd1, 8'h41,    8'h00, 8'h00);
    dir_rows[1]  = mk_row(8'h00,    1'b0, 1'b1, 2'd1, 8'h00,    8'h00, 8'h00);
    dir_rows[2]  = mk_row(8'hFF,    1'b0, 1'b1, 2'd1, 8'hFF,    8'h00, 8'h00);
    dir_rows[3]  = mk_row(PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[4]  = mk_row(8'h34,    1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[5]  = mk_row(8'h31,    1'b0, 1'b1, 2'd1, 8'h41,    8'h00, 8'h00);
    dir_rows[6]  = mk_row(PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[7]  = mk_row(8'h66,    1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[8]  = mk_row(8'h46,    1'b0, 1'b1, 2'd1, 8'hFF,    8'h00, 8'h00);
    dir_rows[9]  = mk_row(PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[10] = mk_row(8'h47,    1'b0, 1'b1, 2'd2, PCT_CHAR, 8'h47, 8'h00);
    dir_rows[11] = mk_row(PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[12] = mk_row(8'h61,    1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[13] = mk_row(8'h7A,    1'b0, 1'b1, 2'd3, PCT_CHAR, 8'h61, 8'h7A);
    dir_rows[14] = mk_row(PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[15] = mk_row(PCT_CHAR, 1'b0, 1'b1, 2'd1, PCT_CHAR, 8'h00, 8'h00);
    dir_rows[16] = mk_row(8'h32,    1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[17] = mk_row(8'h30,    1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[18] = mk_row(PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[19] = mk_row(8'h37,    1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[20] = mk_row(PCT_CHAR, 1'b1, 1'b1, 2'd3, PCT_CHAR, 8'h37, PCT_CHAR);
    dir_rows[21] = mk_row(PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[22] = mk_row(8'h34,    1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00);
    dir_rows[23] = mk_row(8'h31,    1'b1, 1'b1, 2'd1, 8'h41,    8'h00, 8'h00);
    dir_rows[24] = mk_row(PCT_CHAR, 1'b1, 1'b1, 2'd1, PCT_CHAR, 8'h00, 8'h00);

    tx_idle_pct = 34;
    rx_idle_pct = 87;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].e);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        tx_idle_pct = 87;
        rx_idle_pct = 34;
      end else if (ph == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // output held off while input keeps coming, so the queue backs up
        long_hold_req = 1'b1;
      end
      start = n_items;
      while (n_items - start < PHASE_ITEMS) send_string();
      wait_drained();
    end

    repeat (8) @(posedge clk);

    $display("%0d bytes in over %0d strings, %0d decoded bytes checked, %0d three-byte runs",
             n_items, n_strings, n_results, n_triples);
    $display("idle mixes: sender-heavy, receiver-heavy, none; one long output hold");
    if (errors == 0) begin
      $display("url_percent_decoder: match");
    end else begin
      $display("url_percent_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/url_percent_decoder_tb.sv
